/* rtl/complex_matrix_multiply_assert.svh */
// assertion macros for the complex matrix multiplier
// used by cmm_ctrl and cmm_datapath, no other dependencies
`ifndef COMPLEX_MATRIX_MULTIPLY_ASSERT_SVH
`define COMPLEX_MATRIX_MULTIPLY_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CMM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmm assertion failed");

// next-cycle implication
`define CMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmm assertion failed");

`else

`define CMM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/cmm_pkg.sv */
// types, constants and helpers for the complex matrix multiplier
// no dependencies
package cmm_pkg;

    localparam int MAX_DIM = 8;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * DIM_W;
    localparam int CFG_W   = 4;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int SUM_W   = 36;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(MAX_DIM);

    typedef enum logic [1:0] {
        KIND_LOAD_A  = 2'd0,
        KIND_LOAD_B  = 2'd1,
        KIND_COMPUTE = 2'd2
    } cmm_kind_t;

    typedef enum logic [1:0] {
        REG_A_ROWS    = 2'd0,
        REG_INNER_LEN = 2'd1,
        REG_B_COLS    = 2'd2
    } cmm_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } cmm_state_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic [DIM_W-1:0]         row;
        logic [DIM_W-1:0]         col;
        logic signed [ELEM_W-1:0] elem_real;
        logic signed [ELEM_W-1:0] elem_imag;
    } cmm_item_t;

    typedef struct packed {
        logic [DIM_W-1:0]        out_row;
        logic [DIM_W-1:0]        out_col;
        logic signed [SUM_W-1:0] prod_real;
        logic signed [SUM_W-1:0] prod_imag;
        logic                    last;
    } cmm_result_t;

    typedef struct packed {
        logic [CFG_W-1:0] a_rows;
        logic [CFG_W-1:0] inner_len;
        logic [CFG_W-1:0] b_cols;
    } cmm_dims_t;

    // one multiply-accumulate step handed to the datapath
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last_k;
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
        logic [DIM_W-1:0]  out_row;
        logic [DIM_W-1:0]  out_col;
        logic              last;
    } cmm_issue_t;

    // store write
    typedef struct packed {
        logic                     en;
        logic                     sel_b;
        logic [ADDR_W-1:0]        addr;
        logic signed [ELEM_W-1:0] elem_real;
        logic signed [ELEM_W-1:0] elem_imag;
    } cmm_write_t;

    // highest index for a dimension register, zero counts as one, large clamps
    function automatic logic [DIM_W-1:0] last_index(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = '0;
        end
        else if (v > CFG_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM - 1);
        end
        else
        begin
            r = DIM_W'(v - CFG_W'(1));
        end
        return r;
    endfunction

endpackage

/* rtl/cmm_ctrl.sv */
// controller: accepts items, sequences row, column and inner index
// depends on cmm_pkg and complex_matrix_multiply_assert.svh
`include "complex_matrix_multiply_assert.svh"

module cmm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cmm_pkg::cmm_item_t item,
    input  cmm_pkg::cmm_dims_t dims,
    input  logic               pipe_busy,
    output logic               busy,
    output cmm_pkg::cmm_issue_t issue,
    output cmm_pkg::cmm_write_t wr
);

    cmm_pkg::cmm_state_t state_reg, state_next;
    logic [cmm_pkg::DIM_W-1:0] r_reg, r_next;
    logic [cmm_pkg::DIM_W-1:0] c_reg, c_next;
    logic [cmm_pkg::DIM_W-1:0] k_reg, k_next;
    logic [cmm_pkg::DIM_W-1:0] nr_last_reg, nr_last_next;
    logic [cmm_pkg::DIM_W-1:0] nc_last_reg, nc_last_next;
    logic [cmm_pkg::DIM_W-1:0] nk_last_reg, nk_last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cmm_pkg::ST_IDLE;
            r_reg       <= '0;
            c_reg       <= '0;
            k_reg       <= '0;
            nr_last_reg <= '0;
            nc_last_reg <= '0;
            nk_last_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            r_reg       <= r_next;
            c_reg       <= c_next;
            k_reg       <= k_next;
            nr_last_reg <= nr_last_next;
            nc_last_reg <= nc_last_next;
            nk_last_reg <= nk_last_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        k_next       = k_reg;
        nr_last_next = nr_last_reg;
        nc_last_next = nc_last_reg;
        nk_last_next = nk_last_reg;
        busy         = (state_reg != cmm_pkg::ST_IDLE);

        wr.en        = 1'b0;
        wr.sel_b     = 1'b0;
        wr.addr      = {item.row, item.col};
        wr.elem_real = item.elem_real;
        wr.elem_imag = item.elem_imag;

        issue.valid   = (state_reg == cmm_pkg::ST_RUN);
        issue.first   = (k_reg == '0);
        issue.last_k  = (k_reg == nk_last_reg);
        issue.a_addr  = {r_reg, k_reg};
        issue.b_addr  = {k_reg, c_reg};
        issue.out_row = r_reg;
        issue.out_col = c_reg;
        issue.last    = (r_reg == nr_last_reg) && (c_reg == nc_last_reg)
                        && (k_reg == nk_last_reg);

        case (state_reg)
            cmm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (item.kind)
                        cmm_pkg::KIND_LOAD_A:
                        begin
                            wr.en = 1'b1;
                        end
                        cmm_pkg::KIND_LOAD_B:
                        begin
                            wr.en    = 1'b1;
                            wr.sel_b = 1'b1;
                        end
                        cmm_pkg::KIND_COMPUTE:
                        begin
                            state_next   = cmm_pkg::ST_RUN;
                            r_next       = '0;
                            c_next       = '0;
                            k_next       = '0;
                            nr_last_next = cmm_pkg::last_index(dims.a_rows);
                            nk_last_next = cmm_pkg::last_index(dims.inner_len);
                            nc_last_next = cmm_pkg::last_index(dims.b_cols);
                        end
                        default:
                        begin
                            // unused kind, dropped
                        end
                    endcase
                end
            end
            cmm_pkg::ST_RUN:
            begin
                if (k_reg == nk_last_reg)
                begin
                    k_next = '0;
                    if (c_reg == nc_last_reg)
                    begin
                        c_next = '0;
                        if (r_reg == nr_last_reg)
                        begin
                            state_next = cmm_pkg::ST_DRAIN;
                        end
                        else
                        begin
                            r_next = r_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            cmm_pkg::ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = cmm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cmm_pkg::ST_IDLE;
            end
        endcase
    end

    `CMM_ASSERT_IMPL(a_no_issue_idle, clk, rst_n, state_reg == cmm_pkg::ST_IDLE, !issue.valid && !pipe_busy)
    `CMM_ASSERT_NEXT(a_last_drains, clk, rst_n, issue.valid && issue.last, state_reg == cmm_pkg::ST_DRAIN)
    `CMM_ASSERT_NEXT(a_drain_done, clk, rst_n, state_reg == cmm_pkg::ST_DRAIN && !pipe_busy, state_reg == cmm_pkg::ST_IDLE)

endmodule

/* rtl/cmm_datapath.sv */
// datapath: A and B stores, complex multiplier and accumulator
// depends on cmm_pkg and complex_matrix_multiply_assert.svh
`include "complex_matrix_multiply_assert.svh"

module cmm_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmm_pkg::cmm_issue_t  issue,
    input  cmm_pkg::cmm_write_t  wr,
    output logic                 pipe_busy,
    output logic                 valid,
    output cmm_pkg::cmm_result_t result
);

    localparam int DEPTH = cmm_pkg::MAX_DIM * cmm_pkg::MAX_DIM;
    localparam int WORD_W = 2 * cmm_pkg::ELEM_W;
    localparam int DIFF_W = cmm_pkg::PROD_W + 1;

    // word layout: imag in the upper half, real in the lower
    logic [WORD_W-1:0] a_mem [DEPTH];
    logic [WORD_W-1:0] b_mem [DEPTH];

    logic [WORD_W-1:0] a_rd_reg;
    logic [WORD_W-1:0] b_rd_reg;
    logic              v1_reg;
    cmm_pkg::cmm_issue_t tag1_reg;

    logic signed [cmm_pkg::PROD_W-1:0] rr_reg, ii_reg, ri_reg, ir_reg;
    logic              v2_reg;
    cmm_pkg::cmm_issue_t tag2_reg;

    logic signed [cmm_pkg::SUM_W-1:0] acc_re_reg, acc_im_reg;
    logic signed [cmm_pkg::SUM_W-1:0] acc_re_next, acc_im_next;
    logic signed [DIFF_W-1:0] term_re, term_im;
    logic              out_valid_reg;
    cmm_pkg::cmm_result_t out_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en && !wr.sel_b)
        begin
            a_mem[wr.addr] <= {wr.elem_imag, wr.elem_real};
        end
        if (wr.en && wr.sel_b)
        begin
            b_mem[wr.addr] <= {wr.elem_imag, wr.elem_real};
        end
    end

    // stage 1: registered store reads
    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            a_rd_reg <= a_mem[issue.a_addr];
            b_rd_reg <= b_mem[issue.b_addr];
            tag1_reg <= issue;
        end
    end

    // stage 2: four partial products
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            rr_reg   <= $signed(a_rd_reg[cmm_pkg::ELEM_W-1:0])
                        * $signed(b_rd_reg[cmm_pkg::ELEM_W-1:0]);
            ii_reg   <= $signed(a_rd_reg[WORD_W-1:cmm_pkg::ELEM_W])
                        * $signed(b_rd_reg[WORD_W-1:cmm_pkg::ELEM_W]);
            ri_reg   <= $signed(a_rd_reg[cmm_pkg::ELEM_W-1:0])
                        * $signed(b_rd_reg[WORD_W-1:cmm_pkg::ELEM_W]);
            ir_reg   <= $signed(a_rd_reg[WORD_W-1:cmm_pkg::ELEM_W])
                        * $signed(b_rd_reg[cmm_pkg::ELEM_W-1:0]);
            tag2_reg <= tag1_reg;
        end
    end

    // stage 3: combine and accumulate
    always_comb
    begin
        term_re = DIFF_W'(rr_reg) - DIFF_W'(ii_reg);
        term_im = DIFF_W'(ri_reg) + DIFF_W'(ir_reg);
        if (tag2_reg.first)
        begin
            acc_re_next = cmm_pkg::SUM_W'(term_re);
            acc_im_next = cmm_pkg::SUM_W'(term_im);
        end
        else
        begin
            acc_re_next = acc_re_reg + cmm_pkg::SUM_W'(term_re);
            acc_im_next = acc_im_reg + cmm_pkg::SUM_W'(term_im);
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
        if (v2_reg && tag2_reg.last_k)
        begin
            out_reg.out_row   <= tag2_reg.out_row;
            out_reg.out_col   <= tag2_reg.out_col;
            out_reg.prod_real <= acc_re_next;
            out_reg.prod_imag <= acc_im_next;
            out_reg.last      <= tag2_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= issue.valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg && tag2_reg.last_k;
        end
    end

    assign pipe_busy = v1_reg || v2_reg;
    assign valid     = out_valid_reg;
    assign result    = out_reg;

    `CMM_ASSERT_IMPL(a_no_load_in_run, clk, rst_n, wr.en, !issue.valid && !v1_reg && !v2_reg)
    `CMM_ASSERT_NEXT(a_sum_emitted, clk, rst_n, v2_reg && tag2_reg.last_k, out_valid_reg)
    `CMM_ASSERT_NEXT(a_gap_after_last, clk, rst_n, out_valid_reg && out_reg.last, !out_valid_reg)

endmodule

/* rtl/complex_matrix_multiply.sv */
// top level of the complex matrix multiplier: register port and wiring
// depends on cmm_pkg, cmm_ctrl and cmm_datapath
//
// usage
//   item channel: an item is taken at a rising edge with start high and busy
//   low. kind load A / load B writes elem_real, elem_imag at (row, col) of
//   the chosen 8x8 store; busy stays low, so loads can
//   be issued every cycle. an unused kind is dropped.
//   kind compute emits every product element, row outer, column inner.
//   result channel: valid is high for exactly one cycle per element with
//   out_row, out_col, prod_real, prod_imag and last on result; the
//   receiver cannot stall, so each element must be taken when shown.
//   timing: one complex multiply-accumulate per cycle through a shared
//   unit (store read, multiply, accumulate stages). each element shows once
//   its last inner step leaves the accumulate stage; busy stays high from
//   the compute item until the pipeline has drained.
//   registers (apb, byte address 4*i): a_rows, inner_len, b_cols, 4 bits
//   each; 0 acts as 1, above 8 acts as 8. write only while idle.
//   reset: dimension registers go to 8, the block goes idle, store
//   contents stay undefined until loaded.
module complex_matrix_multiply (
    input  logic                 clk,
    input  logic                 rst_n,
    // item channel
    input  logic                 start,
    input  cmm_pkg::cmm_item_t   item,
    output logic                 busy,
    // result channel
    output logic                 valid,
    output cmm_pkg::cmm_result_t result,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    cmm_pkg::cmm_dims_t  dims_reg;
    cmm_pkg::cmm_issue_t issue;
    cmm_pkg::cmm_write_t wr;
    logic                pipe_busy;
    logic                cfg_write;

    // register file, pready is tied high so no access is ever stretched
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg.a_rows    <= cmm_pkg::DIM_RESET;
            dims_reg.inner_len <= cmm_pkg::DIM_RESET;
            dims_reg.b_cols    <= cmm_pkg::DIM_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                cmm_pkg::REG_A_ROWS:    dims_reg.a_rows    <= pwdata[cmm_pkg::CFG_W-1:0];
                cmm_pkg::REG_INNER_LEN: dims_reg.inner_len <= pwdata[cmm_pkg::CFG_W-1:0];
                cmm_pkg::REG_B_COLS:    dims_reg.b_cols    <= pwdata[cmm_pkg::CFG_W-1:0];
                default:
                begin
                    // no register here, write ignored
                end
            endcase
        end
    end

    // read back, unmapped addresses read zero
    always_comb
    begin
        case (paddr[3:2])
            cmm_pkg::REG_A_ROWS:    prdata = 32'(dims_reg.a_rows);
            cmm_pkg::REG_INNER_LEN: prdata = 32'(dims_reg.inner_len);
            cmm_pkg::REG_B_COLS:    prdata = 32'(dims_reg.b_cols);
            default:                prdata = '0;
        endcase
    end

    // sequencing of loads and the row / column / inner loops
    cmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .dims      (dims_reg),
        .pipe_busy (pipe_busy),
        .busy      (busy),
        .issue     (issue),
        .wr        (wr)
    );

    // stores and the multiply-accumulate pipeline
    cmm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .wr        (wr),
        .pipe_busy (pipe_busy),
        .valid     (valid),
        .result    (result)
    );

endmodule
